FILE: hw/rtl/fixed_point_alu_macros.svh
// Assertion macros for the fixed-point ALU checkers.
// Depends on a clk and rst_n in the scope of use.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FXALU_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define FXALU_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/fxalu_pkg.sv
// Shared types, opcodes and the saturation helper for the fixed-point ALU.
// No dependencies.
`timescale 1ns / 1ps

package fxalu_pkg;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_LE, OP_GE,
        OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TOINT, OP_FROMINT
    } func_t;

    typedef struct packed {
        logic [31:0] res;
        logic        ovf;
        logic        dz;
        logic        is_div;
        logic        neg;
    } side_t;

    typedef struct packed {
        logic [31:0] res;
        logic        ovf;
    } sat_t;

    localparam logic signed [63:0] S32_MAX64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN64 = 64'shFFFF_FFFF_8000_0000;

    function automatic sat_t sat64(input logic signed [63:0] v);
        sat_t s;
        if (v > S32_MAX64)
        begin
            s.res = 32'h7FFF_FFFF;
            s.ovf = 1'b1;
        end
        else if (v < S32_MIN64)
        begin
            s.res = 32'h8000_0000;
            s.ovf = 1'b1;
        end
        else
        begin
            s.res = v[31:0];
            s.ovf = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/fxalu_pre.sv
// Front stages: operand capture with multiply, then result of all direct
// operations and divider setup. Depends on fxalu_pkg.
`timescale 1ns / 1ps

module fxalu_pre
    import fxalu_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [3:0]              func,
    input  logic signed [31:0]      operand_a,
    input  logic signed [31:0]      operand_b,
    output logic                    out_valid,
    output side_t                   out_side,
    output logic [32+FRAC_BITS-1:0] out_num,
    output logic [31:0]             out_den
);

    localparam int DW = 32 + FRAC_BITS;
    localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

    logic               v1_reg;
    func_t              func1_reg;
    logic signed [31:0] a1_reg;
    logic signed [31:0] b1_reg;
    logic signed [63:0] prod1_reg;

    logic               v2_reg;
    side_t              side2_reg;
    logic [DW-1:0]      num2_reg;
    logic [31:0]        den2_reg;

    side_t              side_next;
    logic [DW-1:0]      num_next;
    logic [31:0]        den_next;
    logic [31:0]        mag_a;
    logic signed [63:0] mul_adj;
    logic signed [63:0] wide_a;
    logic signed [63:0] wide_b;
    logic               lt;
    logic               gt;
    logic               eq;
    sat_t               s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg <= func_t'(func);
            a1_reg    <= operand_a;
            b1_reg    <= operand_b;
            prod1_reg <= operand_a * operand_b;
            side2_reg <= side_next;
            num2_reg  <= num_next;
            den2_reg  <= den_next;
        end
    end

    always_comb
    begin
        wide_a   = 64'(a1_reg);
        wide_b   = 64'(b1_reg);
        lt       = a1_reg < b1_reg;
        gt       = a1_reg > b1_reg;
        eq       = a1_reg == b1_reg;
        mag_a    = a1_reg[31] ? 32'(-a1_reg) : a1_reg;
        mul_adj  = prod1_reg + (prod1_reg[63] ? $signed(FRAC_MASK) : 64'sd0);
        num_next = DW'(mag_a) << FRAC_BITS;
        den_next = b1_reg[31] ? 32'(-b1_reg) : b1_reg;
        s        = '0;
        side_next        = '0;
        side_next.neg    = a1_reg[31] ^ b1_reg[31];
        unique case (func1_reg)
            OP_ADD:     s = sat64(wide_a + wide_b);
            OP_SUB:     s = sat64(wide_a - wide_b);
            OP_MUL:     s = sat64(mul_adj >>> FRAC_BITS);
            OP_DIV:
            begin
                side_next.is_div = (b1_reg != 32'sd0);
                side_next.dz     = (b1_reg == 32'sd0);
            end
            OP_LT:      s.res = {31'd0, lt};
            OP_GT:      s.res = {31'd0, gt};
            OP_LE:      s.res = {31'd0, !gt};
            OP_GE:      s.res = {31'd0, !lt};
            OP_EQ:      s.res = {31'd0, eq};
            OP_NE:      s.res = {31'd0, !eq};
            OP_MIN:     s.res = gt ? b1_reg : a1_reg;
            OP_MAX:     s.res = gt ? a1_reg : b1_reg;
            OP_INC:     s = sat64(wide_a + 64'sd1);
            OP_DEC:     s = sat64(wide_a - 64'sd1);
            OP_TOINT:   s.res = a1_reg >>> FRAC_BITS;
            OP_FROMINT: s = sat64(wide_a <<< FRAC_BITS);
        endcase
        side_next.res = s.res;
        side_next.ovf = s.ovf;
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;
    assign out_num   = num2_reg;
    assign out_den   = den2_reg;

endmodule

FILE: hw/rtl/fxalu_div_stage.sv
// One restoring-division step: one quotient bit per stage, with side data.
// Depends on fxalu_pkg.
`timescale 1ns / 1ps

module fxalu_div_stage
    import fxalu_pkg::*;
#(
    parameter int DW = 40
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  side_t         in_side,
    input  logic [DW-1:0] in_num,
    input  logic [31:0]   in_rem,
    input  logic [31:0]   in_den,
    output logic          out_valid,
    output side_t         out_side,
    output logic [DW-1:0] out_num,
    output logic [31:0]   out_rem,
    output logic [31:0]   out_den
);

    logic          valid_reg;
    side_t         side_reg;
    logic [DW-1:0] num_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;

    logic [32:0]   rem2;
    logic          ge;
    logic [31:0]   rem_next;
    logic [DW-1:0] num_next;

    always_comb
    begin
        rem2     = {in_rem, in_num[DW-1]};
        ge       = rem2 >= {1'b0, in_den};
        rem_next = ge ? 32'(rem2 - {1'b0, in_den}) : rem2[31:0];
        num_next = {in_num[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            den_reg  <= in_den;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;

endmodule

FILE: hw/rtl/fixed_point_alu.sv
// Signed fixed-point ALU with FRAC_BITS fraction bits on a fully pipelined
// datapath: one word enters per cycle while the output is not stalled; the
// divider resolves one quotient bit per stage, and every operation travels
// the same pipeline so results stay in order. Overflow saturates; a zero
// divisor returns 0 with its flag.
// Depends on fxalu_pkg, fxalu_pre and fxalu_div_stage.
`timescale 1ns / 1ps

module fixed_point_alu
    import fxalu_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a, operand_b
    input  logic [3:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result
    output logic [1:0]  m_tuser    // overflow, divide_by_zero
);

    localparam int DW = 32 + FRAC_BITS;

    logic          en;
    logic          vw   [0:DW];
    side_t         sw   [0:DW];
    logic [DW-1:0] nw   [0:DW];
    logic [31:0]   rw   [0:DW];
    logic [31:0]   dw   [0:DW];

    logic          out_valid_reg;
    logic [31:0]   out_data_reg;
    logic [1:0]    out_user_reg;

    logic signed [63:0] qv;
    sat_t          qs;
    logic [31:0]   data_next;
    logic [1:0]    user_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    fxalu_pre #(.FRAC_BITS(FRAC_BITS)) u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .func      (s_tuser),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .out_valid (vw[0]),
        .out_side  (sw[0]),
        .out_num   (nw[0]),
        .out_den   (dw[0])
    );
    assign rw[0] = 32'd0;

    for (genvar i = 0; i < DW; i++)
    begin : g_div
        fxalu_div_stage #(.DW(DW)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vw[i]),
            .in_side   (sw[i]),
            .in_num    (nw[i]),
            .in_rem    (rw[i]),
            .in_den    (dw[i]),
            .out_valid (vw[i+1]),
            .out_side  (sw[i+1]),
            .out_num   (nw[i+1]),
            .out_rem   (rw[i+1]),
            .out_den   (dw[i+1])
        );
    end

    always_comb
    begin
        qv = sw[DW].neg ? -$signed(64'(nw[DW])) : $signed(64'(nw[DW]));
        qs = sat64(qv);
        if (sw[DW].is_div)
        begin
            data_next = qs.res;
            user_next = {1'b0, qs.ovf};
        end
        else
        begin
            data_next = sw[DW].res;
            user_next = {sw[DW].dz, sw[DW].ovf};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vw[DW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= data_next;
            out_user_reg <= user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: hw/rtl/fxalu_chk.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu_macros.svh.
`timescale 1ns / 1ps
`include "fixed_point_alu_macros.svh"

module fxalu_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [3:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `FXALU_CHECK(a_dz_zero, m_tvalid && m_tuser[1] |-> m_tdata == 32'd0 && !m_tuser[0], "dz result")
    `FXALU_CHECK(a_ovf_ext, m_tvalid && m_tuser[0] |-> m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000, "ovf value")
    `FXALU_CHECK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stall hold")
    `FXALU_NEVER(a_ready, !m_tvalid && !s_tready, "input blocked while output empty")

endmodule

bind fixed_point_alu fxalu_chk u_chk (.*);

FILE: tb/testbench.sv
// Self-checking testbench for fixed_point_alu: directed and random Q24.8 operations
// with bursty input, stalled output and one long output hold-off.
// Depends on fxalu_pkg and the fixed_point_alu RTL.
`timescale 1ns / 1ps

class alu_scoreboard;
    typedef struct {
        logic [31:0] res;
        logic        ovf;
        logic        dz;
    } alu_result_t;

    alu_result_t pending[$];
    int          errors;
    int          checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    function alu_result_t compute(fxalu_pkg::func_t op, logic signed [31:0] a,
                                  logic signed [31:0] b);
        alu_result_t      r;
        longint           wa;
        longint           wb;
        longint           v;
        bit               sat;
        wa    = a;
        wb    = b;
        v     = 0;
        sat   = 1'b1;
        r.dz  = 1'b0;
        case (op)
            fxalu_pkg::OP_ADD: v = wa + wb;
            fxalu_pkg::OP_SUB: v = wa - wb;
            fxalu_pkg::OP_MUL: v = (wa * wb) / 256;
            fxalu_pkg::OP_DIV:
            begin
                if (wb == 0)
                    r.dz = 1'b1;
                else
                    v = (wa * 256) / wb;
            end
            fxalu_pkg::OP_LT: v = (wa < wb);
            fxalu_pkg::OP_GT: v = (wa > wb);
            fxalu_pkg::OP_LE: v = (wa <= wb);
            fxalu_pkg::OP_GE: v = (wa >= wb);
            fxalu_pkg::OP_EQ: v = (wa == wb);
            fxalu_pkg::OP_NE: v = (wa != wb);
            fxalu_pkg::OP_MIN: v = (wa > wb) ? wb : wa;
            fxalu_pkg::OP_MAX: v = (wa > wb) ? wa : wb;
            fxalu_pkg::OP_INC: v = wa + 1;
            fxalu_pkg::OP_DEC: v = wa - 1;
            fxalu_pkg::OP_TOINT: v = wa >>> 8;
            default: v = wa * 256;
        endcase
        r.ovf = 1'b0;
        if (v > 64'sd2147483647)
        begin
            v     = 64'sd2147483647;
            r.ovf = 1'b1;
        end
        else if (v < -64'sd2147483648)
        begin
            v     = -64'sd2147483648;
            r.ovf = 1'b1;
        end
        r.res = v[31:0];
        return r;
    endfunction

    function void note_input(fxalu_pkg::func_t op, logic [31:0] a, logic [31:0] b);
        pending.push_back(compute(op, a, b));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch #%0d on %s: got %h, expected %h", checked, what, got, want);
        errors++;
    endtask

    task check_result(logic [31:0] res, logic ovf, logic dz);
        alu_result_t e;
        if (pending.size() == 0)
        begin
            $display("unexpected word %h", res);
            errors++;
        end
        else
        begin
            e = pending.pop_front();
            if (res !== e.res)
                report("result", res, e.res);
            if (ovf !== e.ovf)
                report("overflow", ovf, e.ovf);
            if (dz !== e.dz)
                report("divide_by_zero", dz, e.dz);
        end
        checked++;
    endtask
endclass

module testbench;
    import fxalu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // operand_a, operand_b
    logic [3:0]  s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // result
    logic [1:0]  m_tuser;   // overflow, divide_by_zero

    alu_scoreboard scb;
    bit            hold_off;
    bit            stim_done;
    int            sent;

    fixed_point_alu uut (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
            1: return 32'h8000_0000 + $urandom_range(0, 2);
            2: return 32'($urandom_range(0, 4)) - 32'd2;
            3: return 32'($signed($urandom_range(0, 131072)) - 65536);
            4: return 32'($urandom_range(0, 8)) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task send_word(func_t op, logic [31:0] a, logic [31:0] b);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        scb.note_input(op, a, b);
        sent++;
    endtask

    task drive_all();
        logic [31:0] ext[6];
        int          burst;
        logic [31:0] a;
        logic [31:0] b;
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'hFFFF_FF00};
        for (int k = 0; k < 16; k++)
            send_word(func_t'(k), ext[k % 6], ext[(k + 1) % 6]);
        send_word(OP_DIV, 32'h1234, 32'h0);
        send_word(OP_DIV, 32'h8000_0000, 32'h0);
        send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_word(OP_DIV, 32'h7FFF_FFFF, 32'h1);
        send_word(OP_INC, 32'h7FFF_FFFF, 32'h0);
        send_word(OP_DEC, 32'h8000_0000, 32'h0);
        send_word(OP_TOINT, 32'hFFFF_FF01, 32'h0);
        send_word(OP_EQ, 32'h55, 32'h55);
        send_word(OP_MIN, 32'h55, 32'h55);
        while (sent < 1525)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
            begin
                a = pick_operand();
                b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
                send_word(func_t'($urandom_range(0, 15)), a, b);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // receiver stall pattern, overridden by the long hold-off
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (sent > 1100)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
        if (rst_n && m_tvalid && m_tready)
            scb.check_result(m_tdata, m_tuser[0], m_tuser[1]);
    end

    initial
    begin
        scb       = new();
        hold_off  = 1'b0;
        stim_done = 1'b0;
        sent      = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_all();
        stim_done = 1'b1;
    end

    initial
    begin
        wait (sent >= 400);
        hold_off = 1'b1;
        repeat (300)
            @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        wait (stim_done);
        while (scb.pending.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        $display("%0d operations driven, %0d results checked, all 16 functions covered",
                 sent, scb.checked);
        if (scb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", scb.pending.size());
        $display("testbench NOT OK");
        $finish;
    end
endmodule

FILE: fixed_point_alu.f
+incdir+hw/rtl
hw/rtl/fxalu_pkg.sv
hw/rtl/fxalu_pre.sv
hw/rtl/fxalu_div_stage.sv
hw/rtl/fixed_point_alu.sv
hw/rtl/fxalu_chk.sv
tb/testbench.sv
